FILE: rtl/mcpf_pkg.sv
// Shared types, codes and constants of the MQTT control packet framer.
package mcpf_pkg;

  // Default width of the length fields that the framer honors
  localparam int DEF_LENGTH_WIDTH = 16;

  // Item operation codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Packet kinds
  localparam logic [1:0] KIND_CONNECT     = 2'd0;
  localparam logic [1:0] KIND_SUBSCRIBE   = 2'd1;
  localparam logic [1:0] KIND_UNSUBSCRIBE = 2'd2;
  localparam logic [1:0] KIND_PUBLISH     = 2'd3;

  // Fixed header bytes
  localparam logic [7:0] HDR_CONNECT     = 8'h10;
  localparam logic [7:0] HDR_SUBSCRIBE   = 8'h82;
  localparam logic [7:0] HDR_UNSUBSCRIBE = 8'hA2;
  localparam logic [7:0] HDR_PUBLISH     = 8'h30;

  // Connect flags
  localparam logic [7:0] FLAGS_BASE = 8'h02;
  localparam logic [7:0] FLAG_USER  = 8'h80;
  localparam logic [7:0] FLAG_PASS  = 8'h40;

  // Connect variable header: protocol name, level, flags, keep alive
  localparam int HEAD_LEN       = 10;
  localparam int HEAD_FLAGS_POS = 7;
  localparam logic [7:0] CONNECT_HEAD [HEAD_LEN] = '{
    8'h00, 8'h04, 8'h4D, 8'h51, 8'h54, 8'h54, 8'h04, 8'h00, 8'h00, 8'd60
  };

  // Subscribe and unsubscribe packet identifier
  localparam logic [15:0] SUB_PACKET_ID = 16'h0001;

  // Remaining length: three base-128 digits
  localparam int RL_W = 21;

  // Byte slots of one command, in emission order
  localparam int SLOT_DATA    = 0;
  localparam int SLOT_HDR     = 1;
  localparam int SLOT_RL0     = 2;
  localparam int SLOT_RL1     = 3;
  localparam int SLOT_RL2     = 4;
  localparam int SLOT_HEAD0   = 5;
  localparam int SLOT_SUBID_HI = SLOT_HEAD0 + HEAD_LEN;
  localparam int SLOT_SUBID_LO = SLOT_SUBID_HI + 1;
  localparam int SLOT_PFX1_HI = SLOT_SUBID_LO + 1;
  localparam int SLOT_PFX1_LO = SLOT_PFX1_HI + 1;
  localparam int SLOT_PFX2_HI = SLOT_PFX1_LO + 1;
  localparam int SLOT_PFX2_LO = SLOT_PFX2_HI + 1;
  localparam int SLOT_QOS     = SLOT_PFX2_LO + 1;
  localparam int NUM_SLOTS    = SLOT_QOS + 1;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // One classified item: which slots to emit and the bytes behind them
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 closes;
    logic [7:0]           data;
    logic [7:0]           hdr;
    logic [7:0]           rl0;
    logic [7:0]           rl1;
    logic [7:0]           rl2;
    logic [7:0]           flags;
    logic [15:0]          pfx1;
    logic [15:0]          pfx2;
    logic [1:0]           qos;
  } mcpf_cmd_t;

endpackage

FILE: rtl/mcpf_front.sv
// Front end: tracks packet state and classifies each item into a byte command.
module mcpf_front import mcpf_pkg::*; #(
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        op,
  input  logic [1:0]  kind,
  input  logic [15:0] first_len,
  input  logic [15:0] second_len,
  input  logic [15:0] third_len,
  input  logic [1:0]  qos,
  input  logic [7:0]  data_byte,
  output logic        cmd_valid,
  output mcpf_cmd_t   cmd
);

  logic [LENGTH_WIDTH-1:0] l1, l2, l3;
  logic [1:0]              q_sat;
  logic                    is_begin, byte_live, take;

  logic                    open_r, open_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic [LENGTH_WIDTH-1:0] left_r, left_nxt;
  logic [LENGTH_WIDTH-1:0] ll0_r, ll0_nxt;
  logic [LENGTH_WIDTH-1:0] ll1_r, ll1_nxt;
  logic [1:0]              qos_r, qos_nxt;
  logic [15:0]             pid_r, pid_nxt;

  logic [1:0]              adv_kind, adv_idx_in, adv_qos, adv_idx;
  logic [LENGTH_WIDTH-1:0] adv_left_in, adv_ll0, adv_ll1, adv_left;
  logic                    adv_pfx2_en, adv_qos_en, adv_close;
  logic [15:0]             adv_pfx2, adv_pid, pid_inc, pid_next_id;

  logic [RL_W-1:0]         rl, rl_add2, rl_add3;
  logic [4:0]              rl_base;
  logic                    is_connect;

  assign l1 = first_len[LENGTH_WIDTH-1:0];
  assign l2 = second_len[LENGTH_WIDTH-1:0];
  assign l3 = third_len[LENGTH_WIDTH-1:0];
  assign q_sat = (qos == 2'd3) ? 2'd2 : qos;

  assign is_begin   = (op == OP_BEGIN);
  assign byte_live  = (op == OP_BYTE) && open_r && (left_r != '0);
  assign take       = accept && (is_begin || byte_live);
  assign is_connect = (kind == KIND_CONNECT);

  // Select what the section walk starts from
  always_comb begin
    if (is_begin) begin
      adv_kind    = kind;
      adv_idx_in  = 2'd0;
      adv_left_in = l1;
      adv_ll0     = (is_connect || kind == KIND_PUBLISH) ? l2 : '0;
      adv_ll1     = is_connect ? l3 : '0;
      adv_qos     = q_sat;
    end else begin
      adv_kind    = kind_r;
      adv_idx_in  = idx_r;
      adv_left_in = left_r - LENGTH_WIDTH'(1);
      adv_ll0     = ll0_r;
      adv_ll1     = ll1_r;
      adv_qos     = qos_r;
    end
  end

  assign pid_inc     = pid_r + 16'd1;
  assign pid_next_id = (pid_inc == 16'd0) ? 16'd1 : pid_inc;

  // Walk past finished sections: insert prefix, identifier or qos byte
  always_comb begin
    adv_pfx2_en = 1'b0;
    adv_pfx2    = '0;
    adv_qos_en  = 1'b0;
    adv_close   = 1'b0;
    adv_idx     = adv_idx_in;
    adv_left    = adv_left_in;
    adv_pid     = pid_r;
    if (adv_left_in == '0) begin
      case (adv_kind)
        KIND_CONNECT: begin
          if (adv_idx_in == 2'd0 && adv_ll0 != '0) begin
            adv_pfx2_en = 1'b1;
            adv_pfx2    = 16'(adv_ll0);
            adv_idx     = 2'd1;
            adv_left    = adv_ll0;
          end else if (adv_idx_in != 2'd2 && adv_ll1 != '0) begin
            adv_pfx2_en = 1'b1;
            adv_pfx2    = 16'(adv_ll1);
            adv_idx     = 2'd2;
            adv_left    = adv_ll1;
          end else begin
            adv_close = 1'b1;
          end
        end
        KIND_PUBLISH: begin
          if (adv_idx_in == 2'd0) begin
            if (adv_qos != 2'd0) begin
              adv_pfx2_en = 1'b1;
              adv_pfx2    = pid_next_id;
              adv_pid     = pid_next_id;
            end
            adv_idx  = 2'd1;
            adv_left = adv_ll0;
            if (adv_ll0 == '0) adv_close = 1'b1;
          end else begin
            adv_close = 1'b1;
          end
        end
        KIND_SUBSCRIBE: begin
          adv_qos_en = 1'b1;
          adv_close  = 1'b1;
        end
        default: begin
          adv_close = 1'b1;
        end
      endcase
      if (adv_close) begin
        adv_idx  = 2'd0;
        adv_left = '0;
      end
    end
  end

  // Remaining length: base plus sections that are sent
  always_comb begin
    rl_add3 = '0;
    case (kind)
      KIND_CONNECT: begin
        rl_base = 5'd12;
        rl_add2 = (l2 != '0) ? RL_W'(l2) + RL_W'(2) : '0;
        rl_add3 = (l3 != '0) ? RL_W'(l3) + RL_W'(2) : '0;
      end
      KIND_PUBLISH: begin
        rl_base = (q_sat != 2'd0) ? 5'd4 : 5'd2;
        rl_add2 = RL_W'(l2);
      end
      KIND_SUBSCRIBE: begin
        rl_base = 5'd5;
        rl_add2 = '0;
      end
      default: begin
        rl_base = 5'd4;
        rl_add2 = '0;
      end
    endcase
    rl = RL_W'(rl_base) + RL_W'(l1) + rl_add2 + rl_add3;
  end

  // Build the command for the back end
  always_comb begin
    cmd        = '0;
    cmd_valid  = take;
    cmd.closes = adv_close;
    cmd.data   = data_byte;
    cmd.rl0    = {(rl[20:7] != '0), rl[6:0]};
    cmd.rl1    = {(rl[20:14] != '0), rl[13:7]};
    cmd.rl2    = {1'b0, rl[20:14]};
    cmd.flags  = FLAGS_BASE | ((l2 != '0) ? FLAG_USER : 8'h00) |
                 ((l3 != '0) ? FLAG_PASS : 8'h00);
    cmd.pfx1   = 16'(l1);
    cmd.pfx2   = adv_pfx2;
    cmd.qos    = adv_qos;
    case (kind)
      KIND_CONNECT:   cmd.hdr = HDR_CONNECT;
      KIND_SUBSCRIBE: cmd.hdr = HDR_SUBSCRIBE;
      KIND_PUBLISH:   cmd.hdr = HDR_PUBLISH | {5'b0, q_sat, 1'b0};
      default:        cmd.hdr = HDR_UNSUBSCRIBE;
    endcase
    if (is_begin) begin
      cmd.mask[SLOT_HDR]     = 1'b1;
      cmd.mask[SLOT_RL0]     = 1'b1;
      cmd.mask[SLOT_RL1]     = (rl[20:7] != '0);
      cmd.mask[SLOT_RL2]     = (rl[20:14] != '0);
      for (int i = 0; i < HEAD_LEN; i++) begin
        cmd.mask[SLOT_HEAD0 + i] = is_connect;
      end
      cmd.mask[SLOT_SUBID_HI] = (kind == KIND_SUBSCRIBE) || (kind == KIND_UNSUBSCRIBE);
      cmd.mask[SLOT_SUBID_LO] = (kind == KIND_SUBSCRIBE) || (kind == KIND_UNSUBSCRIBE);
      cmd.mask[SLOT_PFX1_HI] = 1'b1;
      cmd.mask[SLOT_PFX1_LO] = 1'b1;
    end else begin
      cmd.mask[SLOT_DATA] = 1'b1;
    end
    cmd.mask[SLOT_PFX2_HI] = adv_pfx2_en;
    cmd.mask[SLOT_PFX2_LO] = adv_pfx2_en;
    cmd.mask[SLOT_QOS]     = adv_qos_en;
  end

  // Next packet state
  always_comb begin
    open_nxt = open_r;
    kind_nxt = kind_r;
    idx_nxt  = idx_r;
    left_nxt = left_r;
    ll0_nxt  = ll0_r;
    ll1_nxt  = ll1_r;
    qos_nxt  = qos_r;
    pid_nxt  = pid_r;
    if (take) begin
      open_nxt = !adv_close;
      idx_nxt  = adv_idx;
      left_nxt = adv_left;
      pid_nxt  = adv_pid;
      if (is_begin) begin
        kind_nxt = kind;
        qos_nxt  = q_sat;
        ll0_nxt  = adv_ll0;
        ll1_nxt  = adv_ll1;
      end
    end
  end

  // Hold packet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      kind_r <= KIND_CONNECT;
      idx_r  <= 2'd0;
      left_r <= '0;
      ll0_r  <= '0;
      ll1_r  <= '0;
      qos_r  <= 2'd0;
      pid_r  <= 16'd0;
    end else begin
      open_r <= open_nxt;
      kind_r <= kind_nxt;
      idx_r  <= idx_nxt;
      left_r <= left_nxt;
      ll0_r  <= ll0_nxt;
      ll1_r  <= ll1_nxt;
      qos_r  <= qos_nxt;
      pid_r  <= pid_nxt;
    end
  end

endmodule

FILE: rtl/mcpf_queue.sv
// Short command queue between the front end and the byte sequencer.
module mcpf_queue import mcpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  mcpf_cmd_t wr_data,
  input  logic      rd_en,
  output mcpf_cmd_t rd_data,
  output logic      rd_valid,
  output logic      full
);

  mcpf_cmd_t              slots_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0]   count_r, count_nxt;

  assign rd_data  = slots_r[rd_ptr_r];
  assign rd_valid = (count_r != '0);
  assign full     = (count_r == CMD_CNT_W'(CMD_DEPTH));

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + CMD_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + CMD_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CMD_CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/mcpf_back.sv
// Back end: expands one command into bytes and moves them into the output register, one per cycle while it is free.
module mcpf_back import mcpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  mcpf_cmd_t  q_data,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte,
  output logic       out_packet_end,
  output logic       out_run_end
);

  mcpf_cmd_t            cur_r, cur_nxt;
  logic [NUM_SLOTS-1:0] lowbit, rest;
  logic [7:0]           vals [NUM_SLOTS];
  logic [7:0]           sel_byte;
  logic                 last, out_ready, emit;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_pend_r, out_pend_nxt;
  logic                 out_run_r, out_run_nxt;

  // Byte behind every slot
  always_comb begin
    vals[SLOT_DATA]     = cur_r.data;
    vals[SLOT_HDR]      = cur_r.hdr;
    vals[SLOT_RL0]      = cur_r.rl0;
    vals[SLOT_RL1]      = cur_r.rl1;
    vals[SLOT_RL2]      = cur_r.rl2;
    for (int i = 0; i < HEAD_LEN; i++) begin
      vals[SLOT_HEAD0 + i] = (i == HEAD_FLAGS_POS) ? cur_r.flags : CONNECT_HEAD[i];
    end
    vals[SLOT_SUBID_HI] = SUB_PACKET_ID[15:8];
    vals[SLOT_SUBID_LO] = SUB_PACKET_ID[7:0];
    vals[SLOT_PFX1_HI]  = cur_r.pfx1[15:8];
    vals[SLOT_PFX1_LO]  = cur_r.pfx1[7:0];
    vals[SLOT_PFX2_HI]  = cur_r.pfx2[15:8];
    vals[SLOT_PFX2_LO]  = cur_r.pfx2[7:0];
    vals[SLOT_QOS]      = {6'b0, cur_r.qos};
  end

  // Pick the lowest pending slot
  assign lowbit = cur_r.mask & (~cur_r.mask + NUM_SLOTS'(1));
  assign rest   = cur_r.mask & ~lowbit;
  assign last   = (rest == '0);

  always_comb begin
    sel_byte = 8'h00;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sel_byte = sel_byte | (lowbit[i] ? vals[i] : 8'h00);
    end
  end

  assign out_ready = !out_valid_r || out_pop;
  assign emit      = (cur_r.mask != '0) && out_ready;
  assign q_pop     = q_valid && ((cur_r.mask == '0) || (emit && last));

  // Load the next command or retire the emitted slot
  always_comb begin
    cur_nxt = cur_r;
    if (q_pop) begin
      cur_nxt = q_data;
    end else if (emit) begin
      cur_nxt.mask = rest;
    end
  end

  // Fill the output register when it frees up
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_pend_nxt  = out_pend_r;
    out_run_nxt   = out_run_r;
    if (out_ready) begin
      out_valid_nxt = emit;
      out_byte_nxt  = sel_byte;
      out_pend_nxt  = last && cur_r.closes;
      out_run_nxt   = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_pend_r <= out_pend_nxt;
    out_run_r  <= out_run_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_packet_end = out_pend_r;
  assign out_run_end    = out_run_r;

endmodule

FILE: rtl/mqtt_control_packet_framer.sv
// MQTT 3.1.1 control packet framer: front classifier, command queue, byte sequencer.
//
// Push a begin item (op 0) to start a CONNECT, SUBSCRIBE, UNSUBSCRIBE or PUBLISH
// packet, then push the payload bytes (op 1) of its sections in order. The block
// emits the fixed header, the 1 to 3 byte remaining length, the variable header
// and length prefixes, the subscribe QoS byte and the publish packet identifier,
// flagging the last byte of each item (run_end) and of each packet (packet_end).
// Results leave one byte per clock through a single output byte lane while out_pop
// keeps the output register free; an item yields 1 byte for a plain payload byte,
// up to 3 at a section boundary and up to 18 for a begin item. Plain payload bytes
// stream at one per cycle when the output is not stalled. A byte pushed with no
// packet open, or past the last section, is accepted and dropped. A byte passes
// the command queue, the current-command register and the output register on its
// way out. Lengths are taken from their low LENGTH_WIDTH bits.
module mqtt_control_packet_framer import mcpf_pkg::*; #(
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_first_len,
  input  logic [15:0] in_second_len,
  input  logic [15:0] in_third_len,
  input  logic [1:0]  in_qos,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_run_end
);

  logic      accept;
  logic      cmd_valid, q_valid, q_pop;
  mcpf_cmd_t cmd, q_data;

  assign accept = in_push && !in_full;

  mcpf_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_op),
    .kind       (in_kind),
    .first_len  (in_first_len),
    .second_len (in_second_len),
    .third_len  (in_third_len),
    .qos        (in_qos),
    .data_byte  (in_data_byte),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  mcpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_valid),
    .wr_data  (cmd),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .rd_valid (q_valid),
    .full     (in_full)
  );

  mcpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end),
    .out_run_end    (out_run_end)
  );

endmodule

FILE: rtl/mcpf_checker.sv
// Port-level assertions for the MQTT control packet framer, bound to the top level.
module mcpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_packet_end,
  input logic       out_run_end
);

  // The last byte of a packet is always the last byte of its transaction's item
  a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_packet_end |-> out_run_end)
    else $error("packet_end without run_end");

  // Reset drains the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("output not empty after reset");

  // Reset frees the command queue
  a_reset_room: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_full)
    else $error("input full after reset");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_byte) &&
      $stable(out_packet_end) && $stable(out_run_end))
    else $error("waiting result changed");

endmodule

bind mqtt_control_packet_framer mcpf_checker u_mcpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_byte       (out_byte),
  .out_packet_end (out_packet_end),
  .out_run_end    (out_run_end)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the MQTT control packet framer with its own byte predictor.
module tb;
  import mcpf_pkg::*;

  // Fixed bytes of the serialized packets
  localparam logic [7:0] CONNECT_BYTE     = 8'h10;
  localparam logic [7:0] SUBSCRIBE_BYTE   = 8'h82;
  localparam logic [7:0] UNSUBSCRIBE_BYTE = 8'hA2;
  localparam logic [7:0] PUBLISH_BYTE     = 8'h30;
  localparam logic [7:0] CONN_FLAGS_CLEAN = 8'h02;
  localparam logic [7:0] CONN_FLAG_USER   = 8'h80;
  localparam logic [7:0] CONN_FLAG_PASS   = 8'h40;
  localparam int         FLAGS_SLOT       = 7;
  localparam logic [7:0] CONN_VAR_HEAD [10] = '{
    8'h00, 8'h04, 8'h4D, 8'h51, 8'h54, 8'h54, 8'h04, 8'h00, 8'h00, 8'd60
  };
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_last;
    logic       item_last;
  } framed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = OP_BEGIN;
  logic [1:0]  in_kind = KIND_CONNECT;
  logic [15:0] in_first_len = '0;
  logic [15:0] in_second_len = '0;
  logic [15:0] in_third_len = '0;
  logic [1:0]  in_qos = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_packet_end;
  logic        out_run_end;

  // Framer state as seen by the predictor
  logic        fr_open;
  logic [1:0]  fr_kind;
  logic [2:0]  fr_section;
  logic [15:0] fr_left;
  logic [15:0] fr_later [2];
  logic [1:0]  fr_qos;
  logic [15:0] fr_pub_id;
  logic [7:0]  item_bytes [$];
  logic        item_closed;

  framed_byte_t expected_bytes [$];
  int          mismatches = 0;
  int          items_done = 0;
  int          hold_left = 0;
  bit          calm_input = 1'b0;
  bit          calm_output = 1'b0;

  mqtt_control_packet_framer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_kind        (in_kind),
    .in_first_len   (in_first_len),
    .in_second_len  (in_second_len),
    .in_third_len   (in_third_len),
    .in_qos         (in_qos),
    .in_data_byte   (in_data_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_packet_end (out_packet_end),
    .out_run_end    (out_run_end)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor: emit a 16-bit value MSB first
  function automatic void put16(logic [15:0] v);
    item_bytes.push_back(v[15:8]);
    item_bytes.push_back(v[7:0]);
  endfunction

  function automatic void close_frame();
    fr_open = 1'b0;
    fr_section = '0;
    fr_left = '0;
    item_closed = 1'b1;
  endfunction

  // Walk past finished sections, inserting prefixes, QoS byte and packet id
  function automatic void advance_sections();
    logic [15:0] n;
    while (fr_open && fr_left == 0) begin
      if (fr_kind == KIND_CONNECT) begin
        if (fr_section < 2) begin
          n = fr_later[fr_section[0]];
          fr_section++;
          if (n != 0) begin
            put16(n);
            fr_left = n;
          end
        end else begin
          close_frame();
        end
      end else if (fr_kind == KIND_PUBLISH) begin
        if (fr_section == 0) begin
          if (fr_qos != 0) begin
            fr_pub_id++;
            if (fr_pub_id == 0) fr_pub_id = 16'd1;
            put16(fr_pub_id);
          end
          fr_section = 3'd1;
          fr_left = fr_later[0];
        end else begin
          close_frame();
        end
      end else begin
        if (fr_kind == KIND_SUBSCRIBE) item_bytes.push_back({6'd0, fr_qos});
        close_frame();
      end
    end
  endfunction

  // Start a packet: fixed header, remaining length, variable header, first prefix
  function automatic void begin_packet(logic [1:0] kind, logic [15:0] l1, logic [15:0] l2,
                                       logic [15:0] l3, logic [1:0] qos_req);
    int unsigned rl;
    logic [1:0]  q;
    logic [7:0]  hdr;
    logic [7:0]  digit;
    q = (qos_req > 2'd2) ? 2'd2 : qos_req;
    fr_open = 1'b1;
    fr_kind = kind;
    fr_qos = q;
    fr_section = '0;
    fr_left = l1;
    fr_later[0] = '0;
    fr_later[1] = '0;
    case (kind)
      KIND_CONNECT: begin
        rl = 12 + l1 + ((l2 != 0) ? 2 + l2 : 0) + ((l3 != 0) ? 2 + l3 : 0);
        fr_later[0] = l2;
        fr_later[1] = l3;
        hdr = CONNECT_BYTE;
      end
      KIND_PUBLISH: begin
        rl = 2 + l1 + ((q != 0) ? 2 : 0) + l2;
        fr_later[0] = l2;
        hdr = PUBLISH_BYTE | {5'd0, q, 1'b0};
      end
      KIND_SUBSCRIBE: begin
        rl = 5 + l1;
        hdr = SUBSCRIBE_BYTE;
      end
      default: begin
        rl = 4 + l1;
        hdr = UNSUBSCRIBE_BYTE;
      end
    endcase
    item_bytes.push_back(hdr);
    // Remaining length in base 128, continuation in bit 7
    do begin
      digit = 8'(rl % 128);
      rl = rl / 128;
      if (rl > 0) digit[7] = 1'b1;
      item_bytes.push_back(digit);
    end while (rl > 0);
    if (kind == KIND_CONNECT) begin
      for (int i = 0; i < 10; i++) begin
        if (i == FLAGS_SLOT)
          item_bytes.push_back(CONN_FLAGS_CLEAN | ((l2 != 0) ? CONN_FLAG_USER : 8'h00) |
                               ((l3 != 0) ? CONN_FLAG_PASS : 8'h00));
        else
          item_bytes.push_back(CONN_VAR_HEAD[i]);
      end
    end else if (kind != KIND_PUBLISH) begin
      put16(16'h0001);
    end
    put16(l1);
    advance_sections();
  endfunction

  // Predict the bytes of one accepted transaction; returns how many it yields
  function automatic int frame_item(logic op, logic [1:0] kind, logic [15:0] l1,
                                    logic [15:0] l2, logic [15:0] l3, logic [1:0] qos,
                                    logic [7:0] data);
    framed_byte_t fb;
    item_bytes.delete();
    item_closed = 1'b0;
    if (op == OP_BEGIN) begin
      begin_packet(kind, l1, l2, l3, qos);
    end else if (fr_open && fr_left > 0) begin
      item_bytes.push_back(data);
      fr_left--;
      advance_sections();
    end
    foreach (item_bytes[k]) begin
      fb.data = item_bytes[k];
      fb.item_last = (k == item_bytes.size() - 1);
      fb.pkt_last = fb.item_last && item_closed;
      expected_bytes.push_back(fb);
    end
    return item_bytes.size();
  endfunction

  function automatic int payload_len(logic [1:0] kind, logic [15:0] l1, logic [15:0] l2,
                                     logic [15:0] l3);
    case (kind)
      KIND_CONNECT: return l1 + l2 + l3;
      KIND_PUBLISH: return l1 + l2;
      default:      return l1;
    endcase
  endfunction

  // Offer one transaction, hold it until accepted, then predict its bytes
  task automatic send_item(logic op, logic [1:0] kind, logic [15:0] l1, logic [15:0] l2,
                           logic [15:0] l3, logic [1:0] qos, logic [7:0] data);
    if (!calm_input && $urandom_range(99) < 14) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_kind <= kind;
    in_first_len <= l1;
    in_second_len <= l2;
    in_third_len <= l3;
    in_qos <= qos;
    in_data_byte <= data;
    do @(posedge clk); while (in_full);
    if (frame_item(op, kind, l1, l2, l3, qos, data) > 0) items_done++;
  endtask

  task automatic send_begin(logic [1:0] kind, logic [15:0] l1, logic [15:0] l2,
                            logic [15:0] l3, logic [1:0] qos);
    send_item(OP_BEGIN, kind, l1, l2, l3, qos, 8'($urandom));
  endtask

  // Payload byte; the unused fields carry random values
  task automatic send_byte(logic [7:0] data);
    send_item(OP_BYTE, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              2'($urandom), data);
  endtask

  task automatic send_payload(int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // Pause the input until every expected byte has come out
  task automatic wait_idle();
    in_push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_stray_bytes();
    send_byte(8'hA5);
    send_begin(KIND_UNSUBSCRIBE, 16'd0, 16'hFFFF, 16'hFFFF, 2'd0);
    send_byte(8'h5A);
    wait_idle();
  endtask

  task automatic test_connect();
    send_begin(KIND_CONNECT, 16'd0, 16'd0, 16'd0, 2'd0);
    send_begin(KIND_CONNECT, 16'd1, 16'd1, 16'd1, 2'd3);
    send_payload(3);
    send_begin(KIND_CONNECT, 16'd0, 16'd1, 16'd0, 2'd1);
    send_byte(8'h00);
    send_begin(KIND_CONNECT, 16'd0, 16'd0, 16'd1, 2'd2);
    send_byte(8'hFF);
    // Largest lengths; abandoned by the next begin
    send_begin(KIND_CONNECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_byte(8'h80);
    wait_idle();
  endtask

  task automatic test_subscribe();
    send_begin(KIND_SUBSCRIBE, 16'd0, 16'hFFFF, 16'h0000, 2'd3);
    send_begin(KIND_SUBSCRIBE, 16'd2, 16'd0, 16'd0, 2'd1);
    send_payload(2);
    send_begin(KIND_UNSUBSCRIBE, 16'd1, 16'd0, 16'd0, 2'd2);
    send_byte(8'hFF);
    send_begin(KIND_UNSUBSCRIBE, 16'hFFFF, 16'd0, 16'd0, 2'd0);
    wait_idle();
  endtask

  task automatic test_publish();
    send_begin(KIND_PUBLISH, 16'd0, 16'd0, 16'd0, 2'd0);
    send_begin(KIND_PUBLISH, 16'd1, 16'd1, 16'd0, 2'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h33);
    send_begin(KIND_PUBLISH, 16'd200, 16'd0, 16'd0, 2'd1);
    send_byte(8'h01);
    send_begin(KIND_PUBLISH, 16'd0, 16'hFFFF, 16'd0, 2'd3);
    send_begin(KIND_PUBLISH, 16'd0, 16'd0, 16'd0, 2'd1);
    wait_idle();
  endtask

  // Stall the output for a long stretch while payload keeps coming
  task automatic test_backpressure();
    send_begin(KIND_PUBLISH, 16'd60, 16'd4, 16'd0, 2'd2);
    hold_left = 300;
    send_payload(payload_len(KIND_PUBLISH, 16'd60, 16'd4, 16'd0));
    wait_idle();
  endtask

  task automatic test_random_packets();
    int          goal;
    int          pkt;
    int          need;
    int          pick;
    bit          big;
    logic [1:0]  kind;
    logic [1:0]  qos;
    logic [15:0] l1;
    logic [15:0] l2;
    logic [15:0] l3;
    goal = items_done + 330;
    pkt = 0;
    while (items_done < goal) begin
      calm_input = (pkt >= 20 && pkt < 45);
      calm_output = calm_input;
      kind = 2'($urandom_range(3));
      qos = 2'($urandom_range(3));
      big = ($urandom_range(15) == 0);
      l1 = big ? 16'($urandom) : (($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 5)));
      l2 = (big || kind == KIND_SUBSCRIBE || kind == KIND_UNSUBSCRIBE) ? 16'($urandom) :
           (($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(1, 5)));
      l3 = (big || kind != KIND_CONNECT) ? 16'($urandom) :
           (($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
      send_begin(kind, l1, l2, l3, qos);
      need = payload_len(kind, l1, l2, l3);
      pick = $urandom_range(9);
      // Big packets are abandoned early by the next begin
      if (big) begin
        send_payload($urandom_range(6));
      end else if (pick == 0) begin
        send_payload($urandom_range(need));
      end else begin
        send_payload(need);
        if (pick == 1) send_payload($urandom_range(1, 2));
      end
      pkt++;
    end
    calm_input = 1'b0;
    calm_output = 1'b0;
    wait_idle();
  endtask

  // Drive pop: long hold-offs, calm stretches, otherwise random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_pop <= calm_output || ($urandom_range(99) >= 14);
    end
  end

  function automatic void note_mismatch(string what, framed_byte_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected byte %h pkt_end %b run_end %b, got byte %h pkt_end %b run_end %b",
               $realtime, what, want.data, want.pkt_last, want.item_last,
               out_byte, out_packet_end, out_run_end);
  endfunction

  // Compare each popped byte with the oldest expectation
  always @(posedge clk) begin
    framed_byte_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        want = '0;
        note_mismatch("unexpected transaction", want);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data || out_packet_end !== want.pkt_last ||
            out_run_end !== want.item_last)
          note_mismatch("mismatch", want);
      end
    end
  end

  initial begin
    fr_open = 1'b0;
    fr_kind = KIND_CONNECT;
    fr_section = '0;
    fr_left = '0;
    fr_later[0] = '0;
    fr_later[1] = '0;
    fr_qos = '0;
    fr_pub_id = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_bytes();
    test_connect();
    test_subscribe();
    test_publish();
    test_backpressure();
    test_random_packets();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Give up after a generous bound
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
